/* rtl/fresnel_integral_power_series_unit_assert.svh */
// Assertion macros for the Fresnel power series unit.
// Used by modules that clock on i_clk and reset on i_rst_n.
`ifndef FRESNEL_INTEGRAL_POWER_SERIES_UNIT_ASSERT_SVH
`define FRESNEL_INTEGRAL_POWER_SERIES_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FIPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FIPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fips_pkg.sv */
// Shared types and constants of the Fresnel power series unit.
// No dependencies.
package fips_pkg;

    localparam int TERM_LIMIT_DEF = 16;

    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [30:0] OUT_MAX        = 31'h7FFF_FFFF;
    localparam logic [63:0] ONE_Q56        = 64'h0100_0000_0000_0000;
    localparam logic [63:0] INT64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN      = 64'h8000_0000_0000_0000;

    localparam int          CFG_IDX_W     = 2;
    localparam logic [1:0]  CFG_MAX_TERMS = 2'd0;
    localparam logic [1:0]  CFG_TOLERANCE = 2'd1;
    localparam logic [4:0]  MAX_TERMS_RST = 5'd16;
    localparam logic [31:0] TOL_RST       = 32'd4295;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_U_MUL, S_K_MUL, S_SQRT, S_G_MUL, S_SER_INIT, S_TERM,
        S_T_DIV, S_TG_MUL, S_PU_MUL, S_P_DIV, S_ACC_CHK, S_ACC_MUL, S_NEXT, S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        MSEL_XX, MSEL_XK, MSEL_XR, MSEL_PU, MSEL_TG, MSEL_AG
    } t_msel;

    typedef enum logic {
        DSEL_T, DSEL_P
    } t_dsel;

    typedef struct packed {
        logic  load_x;
        logic  zero_res;
        logic  mul_start;
        t_msel msel;
        logic  sqrt_start;
        logic  div_start;
        t_dsel dsel;
        logic  ser_init;
        logic  cap_conv;
        logic  n_inc;
        logic  store_val;
        logic  store_zero;
        logic  next_series;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic x_zero;
        logic no_terms;
        logic stop;
        logic last;
        logic acc_neg;
        logic series_cos;
        logic out_full;
    } t_stat;

endpackage

/* rtl/fips_ctrl.sv */
// Sequencer of the Fresnel power series unit.
// Depends on fips_pkg; drives the datapath by t_cmd, reads t_stat.
module fips_ctrl
    import fips_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.msel = MSEL_XX;
        o_cmd.dsel = DSEL_T;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_x = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.x_zero) begin
                    o_cmd.zero_res = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.msel = MSEL_XX;
                    n_state = S_U_MUL;
                end
            end
            S_U_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.msel = MSEL_XK;
                    n_state = S_K_MUL;
                end
            end
            S_K_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.msel = MSEL_XR;
                    n_state = S_G_MUL;
                end
            end
            S_G_MUL: begin
                if (i_stat.mul_done) begin
                    n_state = S_SER_INIT;
                end
            end
            S_SER_INIT: begin
                o_cmd.ser_init = 1'b1;
                n_state = i_stat.no_terms ? S_ACC_CHK : S_TERM;
            end
            S_TERM: begin
                o_cmd.div_start = 1'b1;
                o_cmd.dsel = DSEL_T;
                n_state = S_T_DIV;
            end
            S_T_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.msel = MSEL_TG;
                    n_state = S_TG_MUL;
                end
            end
            S_TG_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.cap_conv = 1'b1;
                    if (i_stat.stop || i_stat.last) begin
                        n_state = S_ACC_CHK;
                    end else begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.msel = MSEL_PU;
                        n_state = S_PU_MUL;
                    end
                end
            end
            S_PU_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.dsel = DSEL_P;
                    n_state = S_P_DIV;
                end
            end
            S_P_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.n_inc = 1'b1;
                    n_state = S_TERM;
                end
            end
            S_ACC_CHK: begin
                // a negative sum reads as zero
                if (i_stat.acc_neg) begin
                    o_cmd.store_zero = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.msel = MSEL_AG;
                    n_state = S_ACC_MUL;
                end
            end
            S_ACC_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.store_val = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_stat.series_cos) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.next_series = 1'b1;
                    n_state = S_SER_INIT;
                end
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!i_stat.out_full || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/fips_dpath.sv */
// Datapath of the Fresnel power series unit: registers, a four-pass 64x64
// multiplier, a radix-2 divider and a bit-pair square root. Depends on fips_pkg.
module fips_dpath
    import fips_pkg::*;
#(
    parameter int TERM_LIMIT = TERM_LIMIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_x,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_out_ready,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_valid,
    output logic [30:0]          o_sine_value,
    output logic [30:0]          o_cosine_value,
    output logic                 o_sine_converged,
    output logic                 o_cosine_converged
);

    `include "fresnel_integral_power_series_unit_assert.svh"

    localparam int NW = $clog2(TERM_LIMIT + 1);
    localparam int DW = $clog2(2 * TERM_LIMIT * (2 * TERM_LIMIT + 1) + 1);

    // configuration
    logic [4:0]  r_max_terms;
    logic [31:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_terms <= MAX_TERMS_RST;
            r_tol       <= TOL_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MAX_TERMS) r_max_terms <= i_cfg_data[4:0];
            if (i_cfg_index == CFG_TOLERANCE) r_tol       <= i_cfg_data;
        end
    end

    // working registers
    logic [31:0]   r_x;
    logic [NW-1:0] r_nterms;
    logic [NW-1:0] r_n;
    logic          r_cos;
    logic [63:0]   r_u;
    logic [63:0]   r_gs;
    logic [63:0]   r_g;
    logic [63:0]   r_p;
    logic [63:0]   r_t;
    logic [63:0]   r_acc;
    logic          r_conv;
    logic [30:0]   r_sval;
    logic [30:0]   r_cval;
    logic          r_sconv;
    logic          r_cconv;

    // multiplier
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic [127:0] r_prod;
    logic [63:0]  r_pp;
    logic [1:0]   r_psh;
    logic [2:0]   r_mcnt;
    logic         r_mbusy;
    logic         r_mdone;
    t_msel        r_msel;

    // divider
    logic [63:0]   r_dq;
    logic [DW-1:0] r_dr;
    logic [DW-1:0] r_dd;
    logic [6:0]    r_dcnt;
    logic          r_dbusy;
    logic          r_ddone;
    t_dsel         r_dsel;

    // square root
    logic [63:0] r_sv;
    logic [63:0] r_sres;
    logic [63:0] r_sbit;
    logic        r_sbusy;
    logic        r_sdone;

    // output register
    logic        r_ovalid;
    logic [30:0] r_osval;
    logic [30:0] r_ocval;
    logic        r_osconv;
    logic        r_occonv;

    // combinational helpers
    logic [31:0]   w_ah;
    logic [31:0]   w_bh;
    logic [63:0]   w_pp;
    logic [127:0]  w_add;
    logic [63:0]   w_hi;
    logic [63:0]   w_tolhi;
    logic [63:0]   w_m;
    logic [DW-1:0] w_dt;
    logic [DW-1:0] w_da;
    logic [DW-1:0] w_db;
    logic [DW-1:0] w_dn;
    logic [DW:0]   w_rs;
    logic          w_ge;
    logic [DW:0]   w_rn;
    logic [63:0]   w_qn;
    logic [63:0]   w_tc;
    logic [64:0]   w_sum;
    logic [63:0]   w_accn;
    logic [63:0]   w_sb;
    logic          w_sge;
    logic [42:0]   w_rnd;
    logic [30:0]   w_val;
    logic [NW-1:0] w_nt;

    assign w_ah  = r_mcnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign w_bh  = r_mcnt[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_pp  = w_ah * w_bh;

    always_comb begin
        unique case (r_psh)
            2'd0:    w_add = {64'b0, r_pp};
            2'd1:    w_add = {32'b0, r_pp, 32'b0};
            2'd2:    w_add = {r_pp, 64'b0};
            default: w_add = '0;
        endcase
    end

    assign w_hi    = r_prod[127:64];
    assign w_tolhi = {12'b0, r_tol, 20'b0};
    // saturate (p*u) >> 56 to int64
    assign w_m     = (r_prod[127:119] != 9'd0) ? INT64_MAX : r_prod[119:56];

    assign w_dt = DW'({r_n, 2'b00}) + (r_cos ? DW'(1) : DW'(3));
    assign w_da = DW'({r_n, 1'b0}) + DW'(2);
    assign w_db = r_cos ? (w_da - DW'(1)) : (w_da + DW'(1));
    assign w_dn = DW'(w_da * w_db);

    assign w_rs = {r_dr, r_dq[63]};
    assign w_ge = (w_rs >= {1'b0, r_dd});
    assign w_rn = w_ge ? (w_rs - {1'b0, r_dd}) : w_rs;
    assign w_qn = {r_dq[62:0], w_ge};

    assign w_tc  = w_qn[63] ? INT64_MAX : w_qn;
    assign w_sum = r_n[0] ? ({r_acc[63], r_acc} - {1'b0, w_tc})
                          : ({r_acc[63], r_acc} + {1'b0, w_tc});
    assign w_accn = (w_sum[64] != w_sum[63]) ? (w_sum[64] ? INT64_MIN : INT64_MAX)
                                             : w_sum[63:0];

    assign w_sb  = r_sres + r_sbit;
    assign w_sge = (r_sv >= w_sb);

    // round half up to Q1.30
    assign w_rnd = {1'b0, r_prod[127:86]} + {42'b0, r_prod[85]};
    assign w_val = (w_rnd > {12'b0, OUT_MAX}) ? OUT_MAX : w_rnd[30:0];

    assign w_nt = ({2'b00, r_max_terms} < 7'(TERM_LIMIT)) ? NW'(r_max_terms)
                                                          : NW'(TERM_LIMIT);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy  <= 1'b0;
            r_mdone  <= 1'b0;
            r_mcnt   <= 3'd0;
            r_dbusy  <= 1'b0;
            r_ddone  <= 1'b0;
            r_dcnt   <= 7'd0;
            r_sbusy  <= 1'b0;
            r_sdone  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_mdone <= 1'b0;
            r_ddone <= 1'b0;
            r_sdone <= 1'b0;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= 3'd0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 3'd1;
                if (r_mcnt == 3'd4) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= 7'd64;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt - 7'd1;
                if (r_dcnt == 7'd1) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
            if (i_cmd.sqrt_start) begin
                r_sbusy <= 1'b1;
            end else if (r_sbusy && r_sbit[0]) begin
                r_sbusy <= 1'b0;
                r_sdone <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x      <= i_x;
            r_nterms <= w_nt;
            r_cos    <= 1'b0;
        end
        if (i_cmd.next_series) r_cos <= 1'b1;

        // multiplier
        if (i_cmd.mul_start) begin
            r_msel <= i_cmd.msel;
            r_prod <= '0;
            unique case (i_cmd.msel)
                MSEL_XX: begin r_ma <= {32'b0, r_x}; r_mb <= {32'b0, r_x}; end
                MSEL_XK: begin r_ma <= {32'b0, r_x}; r_mb <= {32'b0, INV_TWO_PI_Q32}; end
                MSEL_XR: begin r_ma <= {32'b0, r_x}; r_mb <= {32'b0, r_sres[31:0]}; end
                MSEL_PU: begin r_ma <= r_p;          r_mb <= r_u; end
                MSEL_TG: begin r_ma <= r_t;          r_mb <= r_g; end
                default: begin r_ma <= r_acc;        r_mb <= r_g; end
            endcase
        end else if (r_mbusy) begin
            if (r_mcnt != 3'd4) begin
                r_pp  <= w_pp;
                r_psh <= {1'b0, r_mcnt[1]} + {1'b0, r_mcnt[0]};
            end
            if (r_mcnt != 3'd0) r_prod <= r_prod + w_add;
        end
        if (r_mdone && r_msel == MSEL_XX) r_u  <= {4'b0, r_prod[63:4]};
        if (r_mdone && r_msel == MSEL_XR) r_gs <= {1'b0, r_prod[63:1]};

        // divider
        if (i_cmd.div_start) begin
            r_dsel <= i_cmd.dsel;
            r_dr   <= '0;
            if (i_cmd.dsel == DSEL_T) begin
                r_dq <= {r_p[62:0], 1'b0};
                r_dd <= w_dt;
            end else begin
                r_dq <= w_m;
                r_dd <= w_dn;
            end
        end else if (r_dbusy) begin
            r_dq <= w_qn;
            r_dr <= w_rn[DW-1:0];
            if (r_dcnt == 7'd1) begin
                if (r_dsel == DSEL_T) begin
                    r_t   <= w_tc;
                    r_acc <= w_accn;
                end else begin
                    r_p <= w_qn;
                end
            end
        end

        // square root, two bits of the radicand a cycle
        if (i_cmd.sqrt_start) begin
            r_sv   <= r_prod[63:0];
            r_sres <= '0;
            r_sbit <= 64'h4000_0000_0000_0000;
        end else if (r_sbusy) begin
            if (w_sge) begin
                r_sv   <= r_sv - w_sb;
                r_sres <= (r_sres >> 1) + r_sbit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end

        // series control
        if (i_cmd.ser_init) begin
            r_g    <= r_cos ? {3'b0, r_sres[31:0], 29'b0} : r_gs;
            r_acc  <= '0;
            r_p    <= ONE_Q56;
            r_n    <= '0;
            r_conv <= 1'b1;
        end
        if (i_cmd.n_inc) r_n <= r_n + NW'(1);
        if (i_cmd.cap_conv) begin
            r_conv <= !((w_hi > w_tolhi) || ((w_hi == w_tolhi) && (r_prod[63:0] != 64'd0)));
        end

        if (i_cmd.store_val || i_cmd.store_zero) begin
            if (r_cos) begin
                r_cval  <= i_cmd.store_val ? w_val : 31'd0;
                r_cconv <= r_conv;
            end else begin
                r_sval  <= i_cmd.store_val ? w_val : 31'd0;
                r_sconv <= r_conv;
            end
        end
        if (i_cmd.zero_res) begin
            r_sval  <= 31'd0;
            r_cval  <= 31'd0;
            r_sconv <= 1'b1;
            r_cconv <= 1'b1;
        end

        if (i_cmd.out_load) begin
            r_osval  <= r_sval;
            r_ocval  <= r_cval;
            r_osconv <= r_sconv;
            r_occonv <= r_cconv;
        end
    end

    always_comb begin
        o_stat.mul_done   = r_mdone;
        o_stat.div_done   = r_ddone;
        o_stat.sqrt_done  = r_sdone;
        o_stat.x_zero     = (r_x == 32'd0);
        o_stat.no_terms   = (r_nterms == '0);
        o_stat.stop       = (w_hi < w_tolhi);
        o_stat.last       = (({1'b0, r_n} + (NW + 1)'(1)) == {1'b0, r_nterms});
        o_stat.acc_neg    = r_acc[63];
        o_stat.series_cos = r_cos;
        o_stat.out_full   = r_ovalid;
    end

    assign o_valid            = r_ovalid;
    assign o_sine_value       = r_osval;
    assign o_cosine_value     = r_ocval;
    assign o_sine_converged   = r_osconv;
    assign o_cosine_converged = r_occonv;

    `FIPS_ASSERT_IMP(a_one_unit, 1'b1, $countones({r_mbusy, r_dbusy, r_sbusy}) <= 1,
        "more than one arithmetic unit busy")
    `FIPS_ASSERT_IMP(a_mul_free, i_cmd.mul_start, !r_mbusy && !r_dbusy && !r_sbusy,
        "multiply started while a unit is busy")
    `FIPS_ASSERT_IMP(a_div_free, i_cmd.div_start, !r_mbusy && !r_dbusy && !r_sbusy,
        "divide started while a unit is busy")
    `FIPS_ASSERT_NXT(a_mul_done, r_mbusy && (r_mcnt == 3'd4) && !i_cmd.mul_start, r_mdone,
        "multiply finished without done")
    `FIPS_ASSERT_IMP(a_out_free, i_cmd.out_load, !r_ovalid || i_out_ready,
        "result overwritten before transfer")

endmodule

/* rtl/fresnel_integral_power_series_unit.sv */
// Fresnel sine and cosine integrals by power series. One item is in work at a
// time. Setup includes the square root. The sine series and then the cosine
// series are summed, each over k terms, where k may be zero. k is at most
// N = min(max_terms, TERM_LIMIT), and fewer when the tolerance is met early.
// A term takes a division and a multiply, and each term but the last one more
// of each. Divisions run on the one-bit-a-cycle divider; multiplies are built
// from four 32x32 partial products. The output register is loaded last. The
// result waits in an output register while the next argument is taken. While
// that register is still full, a finished item holds and the input stalls.
// Depends on fips_pkg, fips_ctrl and fips_dpath.
module fresnel_integral_power_series_unit
    import fips_pkg::*;
#(
    parameter int TERM_LIMIT = TERM_LIMIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_x,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [30:0]          o_sine_value,
    output logic [30:0]          o_cosine_value,
    output logic                 o_sine_converged,
    output logic                 o_cosine_converged,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    fips_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_out_ready (i_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    fips_dpath #(
        .TERM_LIMIT (TERM_LIMIT)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_x                (i_x),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_out_ready        (i_ready),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .o_valid            (o_valid),
        .o_sine_value       (o_sine_value),
        .o_cosine_value     (o_cosine_value),
        .o_sine_converged   (o_sine_converged),
        .o_cosine_converged (o_cosine_converged)
    );

endmodule
